// ===== design/plsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsi_pkg
// Shared widths, codes and beat types of the piecewise linear size
// interpolator.
// ----------------------------------------------------------------------------
package plsi_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_BITS    = 4;
    localparam int CNT_BITS    = 5;
    localparam int VALUE_BITS  = 32;
    localparam int SIZE_BITS   = 10;
    localparam int HALF_BITS   = SIZE_BITS - 1;
    localparam int SQ_BITS     = 2 * HALF_BITS;
    localparam int PROD_BITS   = VALUE_BITS + SQ_BITS;
    localparam int NUM_BITS    = PROD_BITS + 3;
    localparam int QUO_BITS    = SQ_BITS + 2;
    localparam int ADDR_BITS   = 4;

    // Opcodes of an input beat.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_KIND  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    // Result status codes.
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    typedef struct packed {
        logic                         opcode;
        logic [IDX_BITS-1:0]          entry_index;
        logic signed [VALUE_BITS-1:0] break_value;
        logic [SIZE_BITS-1:0]         break_size;
        logic signed [VALUE_BITS-1:0] query_value;
    } cmd_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] out_size;
        logic                 status;
    } rsp_t;

    // Table write request.
    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   addr;
        logic [VALUE_BITS-1:0] value;
        logic [SIZE_BITS-1:0]  size;
    } tbl_wr_t;

    // Divide and root request.
    typedef struct packed {
        logic start;
        logic do_sqrt;
    } ds_req_t;

endpackage : plsi_pkg
`default_nettype wire

// ===== design/plsi_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsi_table
// Breakpoint memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module plsi_table (
    input  wire                            clk,
    input  wire plsi_pkg::tbl_wr_t         wr,
    input  wire [plsi_pkg::IDX_BITS-1:0]   rd_addr,
    output logic [plsi_pkg::VALUE_BITS-1:0] rd_value,
    output logic [plsi_pkg::SIZE_BITS-1:0]  rd_size
);
    import plsi_pkg::*;

    logic [VALUE_BITS-1:0] value_mem [MAX_ENTRIES];
    logic [SIZE_BITS-1:0]  size_mem  [MAX_ENTRIES];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            value_mem[wr.addr] <= wr.value;
            size_mem[wr.addr]  <= wr.size;
        end
    end

    // Registered read port: data follow the address in the next cycle.
    always_ff @(posedge clk)
    begin
        rd_value <= value_mem[rd_addr];
        rd_size  <= size_mem[rd_addr];
    end

endmodule : plsi_table
`default_nettype wire

// ===== design/plsi_divsqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsi_divsqrt
// Bit-serial restoring divider followed by an optional digit-by-digit
// integer square root of the quotient.
// ----------------------------------------------------------------------------
module plsi_divsqrt (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire plsi_pkg::ds_req_t          req,
    input  wire [plsi_pkg::NUM_BITS-1:0]    numer,
    input  wire [plsi_pkg::VALUE_BITS-1:0]  denom,
    output logic                            done,
    output logic [plsi_pkg::SIZE_BITS-1:0]  result
);
    import plsi_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;
    localparam int STEP_BITS = $clog2(NUM_BITS + 1);
    localparam logic [QUO_BITS-1:0] BIT_TOP = QUO_BITS'(1) << (QUO_BITS - 2);

    logic [1:0]            phase_reg, phase_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic                  sqrt_reg, sqrt_next;
    logic [NUM_BITS-1:0]   num_reg, num_next;
    logic [VALUE_BITS-1:0] dv_reg, dv_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0]   quo_reg, quo_next;
    logic [QUO_BITS-1:0]   root_reg, root_next;
    logic [QUO_BITS-1:0]   bit_reg, bit_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   trial;
    logic [QUO_BITS-1:0]   rb;

    assign trial = {rem_reg, num_reg[NUM_BITS-1]};
    assign rb    = root_reg + bit_reg;

    // One quotient bit or one root digit per cycle.
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        sqrt_next  = sqrt_reg;
        num_next   = num_reg;
        dv_next    = dv_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    phase_next = PH_DIV;
                    step_next  = STEP_BITS'(NUM_BITS);
                    sqrt_next  = req.do_sqrt;
                    num_next   = numer;
                    dv_next    = denom;
                    rem_next   = '0;
                    quo_next   = '0;
                end
            end
            PH_DIV:
            begin
                num_next = {num_reg[NUM_BITS-2:0], 1'b0};
                if (trial >= {1'b0, dv_reg})
                begin
                    rem_next = VALUE_BITS'(trial - {1'b0, dv_reg});
                    quo_next = {quo_reg[QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[VALUE_BITS-1:0];
                    quo_next = {quo_reg[QUO_BITS-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1))
                begin
                    if (sqrt_reg)
                    begin
                        phase_next = PH_SQRT;
                        root_next  = '0;
                        bit_next   = BIT_TOP;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            PH_SQRT:
            begin
                if (quo_reg >= rb)
                begin
                    quo_next  = quo_reg - rb;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        sqrt_reg <= sqrt_next;
        num_reg  <= num_next;
        dv_reg   <= dv_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done   = done_reg;
    assign result = sqrt_reg ? root_reg[SIZE_BITS-1:0] : quo_reg[SIZE_BITS-1:0];

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> phase_reg == PH_IDLE)
        else $error("divider started while running");
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(phase_reg) != PH_IDLE)
        else $error("divider done without work");
    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DIV |-> step_reg != '0)
        else $error("divider step count underflow");
`endif

endmodule : plsi_divsqrt
`default_nettype wire

// ===== design/piecewise_linear_size_interpolator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_size_interpolator_core
// Breakpoint table with sequential scan and linear or area interpolation,
// or a step lookup when mode is zero.
// Channel   Signals                          Handshake
// command   start, busy, cmd                 beat taken when start && !busy
// result    rsp_valid, rsp                   one-cycle strobe, never stalled
// config    psel, penable, pwrite, paddr,    APB, pready always high
//           pwdata, prdata, pready
//
// A load is written to the table when accepted. A query scans the table
// entry by entry (memory read, then compare), then for an interpolation
// multiplies twice and runs the bit-serial divide and, for diameters, the
// square root. An empty table answers without a scan. Reset idles the
// control, sets mode to one and kind and count to zero; the table is undefined
// until loaded. The result side cannot stall, so busy is the only back-pressure.
// ----------------------------------------------------------------------------
module piecewise_linear_size_interpolator_core (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire plsi_pkg::cmd_t             cmd,
    output logic                            rsp_valid,
    output plsi_pkg::rsp_t                  rsp,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [plsi_pkg::ADDR_BITS-1:0]   paddr,
    input  wire [31:0]                      pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import plsi_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_MUL1   = 3'd3;
    localparam logic [2:0] S_MUL2   = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DWAIT  = 3'd6;
    localparam logic [VALUE_BITS-1:0] SIGN_BIT = VALUE_BITS'(1) << (VALUE_BITS - 1);

    logic [2:0]            state_reg, state_next;
    logic                  mode_reg, kind_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   cnt_eff;
    logic [IDX_BITS-1:0]   idx_reg, idx_next, last_idx;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [VALUE_BITS-1:0] prev_v_reg, prev_v_next;
    logic [SIZE_BITS-1:0]  prev_s_reg, prev_s_next;
    logic [VALUE_BITS-1:0] a_reg, a_next, b_reg, b_next, dv_reg, dv_next;
    logic [SQ_BITS-1:0]    ma_reg, ma_next, mb_reg, mb_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next, acc_reg, acc_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;
    logic [VALUE_BITS-1:0] rd_value, upper_v;
    logic [SIZE_BITS-1:0]  rd_size;
    logic [HALF_BITS-1:0]  hu, hl;
    logic [PROD_BITS:0]    sum;
    logic [NUM_BITS-1:0]   numer;
    logic                  accept, cfg_wr;
    tbl_wr_t               tbl_wr;
    ds_req_t               ds_req;
    logic                  ds_done;
    logic [SIZE_BITS-1:0]  ds_result;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b1;
            kind_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_KIND:  kind_reg  <= pwdata[0];
                REG_COUNT: count_reg <= pwdata[CNT_BITS-1:0];
                default:   ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:  prdata = {31'd0, mode_reg};
            REG_KIND:  prdata = {31'd0, kind_reg};
            REG_COUNT: prdata = {27'd0, count_reg};
            default:   prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    assign cnt_eff  = (count_reg > CNT_BITS'(MAX_ENTRIES)) ? CNT_BITS'(MAX_ENTRIES)
                                                           : count_reg;
    assign last_idx = IDX_BITS'(cnt_eff - 1'b1);

    // Load beats go straight into the table.
    assign tbl_wr.en    = accept && (cmd.opcode == OP_LOAD);
    assign tbl_wr.addr  = cmd.entry_index;
    assign tbl_wr.value = cmd.break_value;
    assign tbl_wr.size  = cmd.break_size;

    plsi_table u_table (
        .clk      (clk),
        .wr       (tbl_wr),
        .rd_addr  (idx_reg),
        .rd_value (rd_value),
        .rd_size  (rd_size)
    );

    assign upper_v = rd_value ^ SIGN_BIT;
    assign hu      = rd_size[SIZE_BITS-1:1];
    assign hl      = prev_s_reg[SIZE_BITS-1:1];

    // Weighted sum, scaled by four for the area form.
    assign sum   = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign numer = kind_reg ? {sum, 2'b00} : NUM_BITS'(sum);

    assign ds_req.start   = (state_reg == S_DSTART);
    assign ds_req.do_sqrt = kind_reg;

    plsi_divsqrt u_divsqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ds_req),
        .numer  (numer),
        .denom  (dv_reg),
        .done   (ds_done),
        .result (ds_result)
    );

    // Query sequencer.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        q_next         = q_reg;
        prev_v_next    = prev_v_reg;
        prev_s_next    = prev_s_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        dv_next        = dv_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.opcode == OP_QUERY)
                begin
                    if (cnt_eff == '0)
                    begin
                        rsp_valid_next    = 1'b1;
                        rsp_next.out_size = '0;
                        rsp_next.status   = ST_EMPTY;
                    end
                    else
                    begin
                        q_next     = cmd.query_value ^ SIGN_BIT;
                        idx_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                rsp_next.status = ST_OK;
                if (q_reg < upper_v)
                begin
                    if (idx_reg == '0 || !mode_reg || q_reg <= prev_v_reg)
                    begin
                        rsp_valid_next    = 1'b1;
                        rsp_next.out_size = (idx_reg == '0) ? rd_size : prev_s_reg;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        a_next     = q_reg - prev_v_reg;
                        b_next     = upper_v - q_reg;
                        dv_next    = upper_v - prev_v_reg;
                        ma_next    = kind_reg ? hu * hu : SQ_BITS'(rd_size);
                        mb_next    = kind_reg ? hl * hl : SQ_BITS'(prev_s_reg);
                        state_next = S_MUL1;
                    end
                end
                else
                begin
                    prev_v_next = upper_v;
                    prev_s_next = rd_size;
                    if (idx_reg == last_idx)
                    begin
                        rsp_valid_next    = 1'b1;
                        rsp_next.out_size = rd_size;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_MUL1:
            begin
                prod_next  = a_reg * ma_reg;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                acc_next   = prod_reg;
                prod_next  = b_reg * mb_reg;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (ds_done)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.out_size = ds_result;
                    rsp_next.status   = ST_OK;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        prev_v_reg <= prev_v_next;
        prev_s_reg <= prev_s_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        dv_reg     <= dv_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        rsp_reg    <= rsp_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.out_size == '0)
        else $error("empty-table result with nonzero size");
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.opcode == OP_LOAD |=> !busy && !rsp_valid)
        else $error("load produced work or a result");
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> idx_reg <= last_idx)
        else $error("scan beyond entries in use");
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ds_done |-> state_reg == S_DWAIT)
        else $error("divider finished outside wait state");
`endif

endmodule : piecewise_linear_size_interpolator_core
`default_nettype wire
